// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_RST(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("assertion failed");
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_RST(label, clk, rst, prop)
`define ASSERT_CLK(label, clk, prop)
`endif
`endif

// ===== rtl/gcb_pkg.sv =====
// Shared widths, codes and the memory request type of the grid cell binning block.
`default_nettype none
package gcb_pkg;

  localparam int POS_W     = 24;
  localparam int CS_W      = 23;
  localparam int DIM_W     = 7;
  localparam int ID_W      = 12;
  localparam int LINK_W    = 13;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 3;
  localparam int FAR_W     = DIM_W + CS_W;
  localparam int IDX_W     = 2 * DIM_W;
  localparam int WIDE_W    = 17;
  // quotient bits: a cell coordinate stays below the largest grid dimension
  localparam int QW        = DIM_W;
  localparam int STEP_W    = $clog2(QW);
  localparam int DIV_W     = POS_W + QW;

  localparam int MAX_CELLS_DEF = 4096;
  localparam int MAX_PART_DEF  = 4096;

  localparam logic [LINK_W-1:0] EMPTY_CODE = 13'd4096;

  localparam logic [ACT_W-1:0] ACT_CLEAR     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ_HEAD = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ_LINK = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_SIZE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS      = 3'd4;

  typedef struct packed {
    logic              head_re;
    logic              head_we;
    logic [WIDE_W-1:0] head_addr;
    logic [LINK_W-1:0] head_wdata;
    logic              link_re;
    logic              link_we;
    logic [WIDE_W-1:0] link_addr;
    logic [LINK_W-1:0] link_wdata;
  } mem_req_t;

endpackage
`default_nettype wire

// ===== rtl/gcb_div.sv =====
// Shared restoring divider: one quotient bit per cycle for the cell coordinate.
`default_nettype none
module gcb_div import gcb_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [POS_W-1:0] dividend,
  input  logic [CS_W-1:0]  divisor,
  output logic             done,
  output logic [QW-1:0]    quotient
);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [POS_W-1:0]  rem;
  logic [CS_W-1:0]   dvs;
  logic [DIV_W-1:0]  shifted;
  logic [DIV_W-1:0]  trial;
  logic              fits;

  // dividend is known to be below 2**QW times the divisor
  assign shifted = DIV_W'(dvs) << step;
  assign trial   = DIV_W'(rem) - shifted;
  assign fits    = DIV_W'(rem) >= shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && (step == '0);
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (step == '0)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dvs      <= divisor;
      step     <= STEP_W'(QW - 1);
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem            <= trial[POS_W-1:0];
        quotient[step] <= 1'b1;
      end
      step <= step - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/gcb_store.sv =====
// Cell head and particle link memories with registered read data.
`default_nettype none
module gcb_store import gcb_pkg::*; #(
  parameter int MAX_CELLS     = MAX_CELLS_DEF,
  parameter int MAX_PARTICLES = MAX_PART_DEF
) (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [LINK_W-1:0] head_rdata,
  output logic [LINK_W-1:0] link_rdata
);

  localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
  localparam int PW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;

  logic [LINK_W-1:0] heads [MAX_CELLS];
  logic [LINK_W-1:0] links [MAX_PARTICLES];

  always_ff @(posedge clk) begin
    if (req.head_we) begin
      heads[req.head_addr[CW-1:0]] <= req.head_wdata;
    end
    if (req.head_re) begin
      head_rdata <= heads[req.head_addr[CW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (req.link_we) begin
      links[req.link_addr[PW-1:0]] <= req.link_wdata;
    end
    if (req.link_re) begin
      link_rdata <= links[req.link_addr[PW-1:0]];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/spatial_grid_cell_binning.sv =====
// Top level of the uniform grid cell binning block: sequencer, registers, result.
// Insert: an inside point goes through the bound check, then each axis in turn through the shared divider;
// an outside point goes straight from the check to the result. Clear writes one head entry per cycle.
// One item at a time; the next item is taken once the sequencer is back in idle.
// After reset the block sweeps both memories to the empty code with in_ready low;
// configuration registers reset at once and are writable throughout.
`default_nettype none
`include "assert_macros.svh"
module spatial_grid_cell_binning import gcb_pkg::*; #(
  parameter int MAX_CELLS     = MAX_CELLS_DEF,
  parameter int MAX_PARTICLES = MAX_PART_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [POS_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ACT_W-1:0]     action,
  input  logic [ID_W-1:0]      particle_id,
  input  logic signed [POS_W-1:0] pos_x,
  input  logic signed [POS_W-1:0] pos_y,
  input  logic [ID_W-1:0]      cell_to_read,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 inside_res,
  output logic [ID_W-1:0]      cell_index,
  output logic [LINK_W-1:0]    link_value
);

  localparam int INIT_LEN = (MAX_CELLS > MAX_PARTICLES) ? MAX_CELLS : MAX_PARTICLES;
  localparam logic [WIDE_W-1:0] INIT_LAST  = WIDE_W'(INIT_LEN - 1);
  localparam logic [WIDE_W-1:0] CLEAR_LAST = WIDE_W'(MAX_CELLS - 1);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CLEAR = 4'd2;
  localparam logic [3:0] ST_BOUND = 4'd3;
  localparam logic [3:0] ST_CHECK = 4'd4;
  localparam logic [3:0] ST_DIVX  = 4'd5;
  localparam logic [3:0] ST_DIVY  = 4'd6;
  localparam logic [3:0] ST_INDEX = 4'd7;
  localparam logic [3:0] ST_LOOK  = 4'd8;
  localparam logic [3:0] ST_WRITE = 4'd9;
  localparam logic [3:0] ST_DONE  = 4'd10;

  // configuration registers
  logic signed [POS_W-1:0] origin_x;
  logic signed [POS_W-1:0] origin_y;
  logic [CS_W-1:0]         cell_size;
  logic [DIM_W-1:0]        grid_columns;
  logic [DIM_W-1:0]        grid_rows;

  logic [3:0]        state;
  logic [WIDE_W-1:0] cnt;

  // captured request
  logic [ACT_W-1:0]        act_r;
  logic [ID_W-1:0]         pid_r;
  logic signed [POS_W-1:0] pos_x_r;
  logic signed [POS_W-1:0] pos_y_r;
  logic [ID_W-1:0]         rcell_r;

  logic signed [POS_W:0] dx_r;
  logic signed [POS_W:0] dy_r;
  logic [FAR_W-1:0]      far_x;
  logic [FAR_W-1:0]      far_y;
  logic [DIM_W-1:0]      col_r;
  logic [DIM_W-1:0]      row_r;
  logic [IDX_W-1:0]      idx_r;
  logic                  hit_r;

  logic              res_inside;
  logic [ID_W-1:0]   res_cell;
  logic [LINK_W-1:0] res_link;

  logic              in_x;
  logic              in_y;
  logic              idx_ok;
  logic              pid_ok;
  logic              rcell_ok;
  logic              out_free;

  logic              div_start;
  logic [POS_W-1:0]  div_dividend;
  logic              div_done;
  logic [QW-1:0]     div_q;
  logic [DIM_W-1:0]  q_col;
  logic [DIM_W-1:0]  q_row;

  mem_req_t          mem_req;
  logic [LINK_W-1:0] head_rdata;
  logic [LINK_W-1:0] link_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x     <= '0;
      origin_y     <= '0;
      cell_size    <= 23'd256;
      grid_columns <= 7'd64;
      grid_rows    <= 7'd64;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIGIN_X:  origin_x     <= $signed(cfg_data);
        CFG_ORIGIN_Y:  origin_y     <= $signed(cfg_data);
        CFG_CELL_SIZE: cell_size    <= cfg_data[CS_W-1:0];
        CFG_COLUMNS:   grid_columns <= cfg_data[DIM_W-1:0];
        CFG_ROWS:      grid_rows    <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // strict inside test; a zero size or dimension makes the far bound equal the start
  assign in_x = !dx_r[POS_W] && (dx_r != '0) && (FAR_W'(dx_r[POS_W-1:0]) < far_x);
  assign in_y = !dy_r[POS_W] && (dy_r != '0) && (FAR_W'(dy_r[POS_W-1:0]) < far_y);

  assign idx_ok   = WIDE_W'(idx_r) < WIDE_W'(MAX_CELLS);
  assign pid_ok   = WIDE_W'(pid_r) < WIDE_W'(MAX_PARTICLES);
  assign rcell_ok = WIDE_W'(rcell_r) < WIDE_W'(MAX_CELLS);

  // clamp the quotient to the last cell of its axis
  assign q_col = (div_q >= grid_columns) ? grid_columns - 1'b1 : div_q;
  assign q_row = (div_q >= grid_rows) ? grid_rows - 1'b1 : div_q;

  assign div_start    = ((state == ST_CHECK) && in_x && in_y) ||
                        ((state == ST_DIVX) && div_done);
  assign div_dividend = (state == ST_CHECK) ? dx_r[POS_W-1:0] : dy_r[POS_W-1:0];

  gcb_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cell_size),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    mem_req = '0;
    case (state)
      ST_INIT: begin
        mem_req.head_we    = cnt < WIDE_W'(MAX_CELLS);
        mem_req.head_addr  = cnt;
        mem_req.head_wdata = EMPTY_CODE;
        mem_req.link_we    = cnt < WIDE_W'(MAX_PARTICLES);
        mem_req.link_addr  = cnt;
        mem_req.link_wdata = EMPTY_CODE;
      end
      ST_CLEAR: begin
        mem_req.head_we    = 1'b1;
        mem_req.head_addr  = cnt;
        mem_req.head_wdata = EMPTY_CODE;
      end
      ST_LOOK: begin
        if (act_r == ACT_INSERT) begin
          mem_req.head_re   = idx_ok;
          mem_req.head_addr = WIDE_W'(idx_r);
        end else if (act_r == ACT_READ_HEAD) begin
          mem_req.head_re   = rcell_ok;
          mem_req.head_addr = WIDE_W'(rcell_r);
        end else begin
          mem_req.link_re   = pid_ok;
          mem_req.link_addr = WIDE_W'(pid_r);
        end
      end
      ST_WRITE: begin
        // push the particle onto the front of its cell's list
        mem_req.head_we    = (act_r == ACT_INSERT) && hit_r;
        mem_req.head_addr  = WIDE_W'(idx_r);
        mem_req.head_wdata = LINK_W'(pid_r);
        mem_req.link_we    = (act_r == ACT_INSERT) && hit_r;
        mem_req.link_addr  = WIDE_W'(pid_r);
        mem_req.link_wdata = head_rdata;
      end
      default: ;
    endcase
  end

  gcb_store #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_store (
    .clk        (clk),
    .req        (mem_req),
    .head_rdata (head_rdata),
    .link_rdata (link_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
      cnt   <= '0;
    end else begin
      case (state)
        ST_INIT: begin
          cnt <= cnt + 1'b1;
          if (cnt == INIT_LAST) begin
            cnt   <= '0;
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            case (action)
              ACT_CLEAR:  state <= ST_CLEAR;
              ACT_INSERT: state <= ST_BOUND;
              default:    state <= ST_LOOK;
            endcase
          end
        end
        ST_CLEAR: begin
          cnt <= cnt + 1'b1;
          if (cnt == CLEAR_LAST) begin
            cnt   <= '0;
            state <= ST_DONE;
          end
        end
        ST_BOUND: state <= ST_CHECK;
        ST_CHECK: state <= (in_x && in_y) ? ST_DIVX : ST_DONE;
        ST_DIVX: begin
          if (div_done) begin
            state <= ST_DIVY;
          end
        end
        ST_DIVY: begin
          if (div_done) begin
            state <= ST_INDEX;
          end
        end
        ST_INDEX: state <= ST_LOOK;
        ST_LOOK: begin
          if ((act_r == ACT_INSERT) && !idx_ok) begin
            state <= ST_DONE;
          end else begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: state <= ST_DONE;
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          act_r   <= action;
          pid_r   <= particle_id;
          pos_x_r <= pos_x;
          pos_y_r <= pos_y;
          rcell_r <= cell_to_read;
        end
      end
      ST_CLEAR: begin
        res_inside <= 1'b0;
        res_cell   <= '0;
        res_link   <= EMPTY_CODE;
      end
      ST_BOUND: begin
        dx_r  <= {pos_x_r[POS_W-1], pos_x_r} - {origin_x[POS_W-1], origin_x};
        dy_r  <= {pos_y_r[POS_W-1], pos_y_r} - {origin_y[POS_W-1], origin_y};
        far_x <= FAR_W'(grid_columns) * FAR_W'(cell_size);
        far_y <= FAR_W'(grid_rows) * FAR_W'(cell_size);
      end
      ST_CHECK: begin
        res_inside <= 1'b0;
        res_cell   <= '0;
        res_link   <= EMPTY_CODE;
      end
      ST_DIVX: begin
        if (div_done) begin
          col_r <= q_col;
        end
      end
      ST_DIVY: begin
        if (div_done) begin
          row_r <= q_row;
        end
      end
      ST_INDEX: idx_r <= IDX_W'(row_r * grid_columns) + IDX_W'(col_r);
      ST_LOOK: begin
        // cell index beyond the head memory counts as outside
        res_inside <= 1'b0;
        res_cell   <= '0;
        res_link   <= EMPTY_CODE;
        case (act_r)
          ACT_INSERT:    hit_r <= pid_ok;
          ACT_READ_HEAD: hit_r <= rcell_ok;
          default:       hit_r <= pid_ok;
        endcase
      end
      ST_WRITE: begin
        case (act_r)
          ACT_INSERT: begin
            res_inside <= 1'b1;
            res_cell   <= idx_r[ID_W-1:0];
            res_link   <= hit_r ? head_rdata : EMPTY_CODE;
          end
          ACT_READ_HEAD: begin
            res_inside <= 1'b0;
            res_cell   <= rcell_r;
            res_link   <= hit_r ? head_rdata : EMPTY_CODE;
          end
          default: begin
            res_inside <= 1'b0;
            res_cell   <= '0;
            res_link   <= hit_r ? link_rdata : EMPTY_CODE;
          end
        endcase
      end
      default: ;
    endcase
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == ST_DONE) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && out_free) begin
      inside_res <= res_inside;
      cell_index <= res_cell;
      link_value <= res_link;
    end
  end

  `ASSERT_RST(a_busy_after_accept, clk, rst, (in_valid && in_ready) |=> !in_ready)
  `ASSERT_CLK(a_sweep_after_reset, clk, rst |=> !in_ready)
  `ASSERT_RST(a_div_done_owned, clk, rst, div_done |-> (state == ST_DIVX || state == ST_DIVY))
  `ASSERT_RST(a_head_write_state, clk, rst, mem_req.head_we |-> (state == ST_WRITE || state == ST_CLEAR || state == ST_INIT))

endmodule
`default_nettype wire
